// ----- rtl/core/lrrv_pkg.sv -----
// shared types, constants and helper functions for the log record validator
`timescale 1ns / 1ps
`default_nettype none

package lrrv_pkg;

    // node identifier width in bytes (4 to 8)
    localparam int unsigned NODE_ID_BYTES = 4;
    localparam int unsigned NODE_BITS     = 8 * NODE_ID_BYTES;

    localparam int unsigned HDR_LEN   = 41;
    localparam int unsigned CFG_W     = 36;
    localparam int unsigned TDATA_W   = 240;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] GOLDEN    = 32'h9e3779b9;
    localparam logic [31:0] MAX_DIM   = 32'h3FFFFFFF;
    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 36'd536870912;

    // magic, version and opcode bytes in arrival order
    localparam logic [7:0] PREFIX [8] = '{8'h50, 8'h4c, 8'h57, 8'h41,
                                          8'h01, 8'h00, 8'h01, 8'h00};

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_VECTOR   = 2'd1,
        PH_NEIGHBOR = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_VERDICT = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_NODE_WIDE = 3'd2,
        ST_CHECKSUM  = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    typedef struct packed {
        kind_t        kind;
        logic [TDATA_W-1:0] data;
    } result_t;

    // one fnv-1a step
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

    // golden ratio combine of vector and neighbour hashes
    function automatic logic [31:0] hash_combine(input logic [31:0] h, input logic [31:0] n);
        return h ^ (n + GOLDEN + (h << 6) + (h >> 2));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/log_record_replay_validator.sv -----
// Log record deframer and validator: one log byte per cycle in while s_tready is high, checked results out.
// Results are registered in the result queue before they are offered on m_tvalid.
// Throughput: one request per cycle while s_tready is high; the last payload byte gives two results,
// held in a four-entry result queue that drops s_tready only when under two slots are free.
// Reset: rst_n asynchronous active low clears all record state and the queue,
// and sets max_payload_bytes to 536870912.
`timescale 1ns / 1ps
`default_nettype none

module log_record_replay_validator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [lrrv_pkg::CFG_W-1:0]  cfg_wdata,   // max_payload_bytes
    input  wire logic                        s_tvalid,
    output      logic                        s_tready,
    input  wire logic [7:0]                  s_tdata,     // data_byte
    input  wire logic                        s_tuser,     // mode
    output      logic                        m_tvalid,
    input  wire logic                        m_tready,
    // status[2:0] payload_byte[10:3] sequence_number[74:11] node_number[138:75]
    // dimension[168:139] neighbor_total[200:169] deleted_flag[201]
    // computed_checksum[233:202], zero above
    output      logic [lrrv_pkg::TDATA_W-1:0] m_tdata,
    output      logic [1:0]                  m_tuser      // kind
);
    import lrrv_pkg::*;

    // state registers
    logic [CFG_W-1:0] max_payload_reg;
    phase_t      phase_reg, phase_next;
    logic [5:0]  hbc_reg, hbc_next;
    logic        match_reg, match_next;
    logic [63:0] seq_reg, seq_next;
    logic [63:0] node_reg, node_next;
    logic [31:0] dim_reg, dim_next;
    logic [31:0] vsize_reg, vsize_next;
    logic [31:0] ncount_reg, ncount_next;
    logic [7:0]  del_reg, del_next;
    logic [31:0] expsum_reg, expsum_next;
    logic [CFG_W-1:0] remain_reg, remain_next;
    logic [31:0] vhash_reg, vhash_next;
    logic [31:0] nhash_reg, nhash_next;
    logic        halted_reg, halted_next;

    // result queue
    result_t     q_mem [4];
    logic [1:0]  q_wr_reg, q_rd_reg;
    logic [2:0]  q_cnt_reg;
    result_t     res0, res1;
    logic [1:0]  n_res;

    logic accept, pop;
    assign s_tready = (q_cnt_reg <= 3'd2);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (q_cnt_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = q_mem[q_rd_reg].data;
    assign m_tuser  = q_mem[q_rd_reg].kind;

    // pack one result
    function automatic result_t pack(input kind_t k, input status_t st, input logic [7:0] pb,
                                     input logic hdr, input logic [63:0] sq,
                                     input logic [63:0] nd, input logic [31:0] dm,
                                     input logic [31:0] nc, input logic [7:0] dl,
                                     input logic [31:0] sum);
        result_t r;
        r.kind = k;
        r.data = '0;
        r.data[2:0]     = st;
        r.data[10:3]    = pb;
        r.data[74:11]   = hdr ? sq : 64'd0;
        r.data[138:75]  = hdr ? nd : 64'd0;
        r.data[168:139] = hdr ? dm[29:0] : 30'd0;
        r.data[200:169] = hdr ? nc : 32'd0;
        r.data[201]     = hdr ? dl[0] : 1'b0;
        r.data[233:202] = sum;
        return r;
    endfunction

    logic [7:0]       b;
    logic [35:0]      nb_bytes;
    logic [36:0]      total_bytes;
    logic             hdr_ok, node_fits;
    logic [31:0]      fnv_out, comb_h, fin_h;
    logic [CFG_W-1:0] rem_dec;

    assign b = s_tdata;

    // record datapath: next state and results for the accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        hbc_next    = hbc_reg;
        match_next  = match_reg;
        seq_next    = seq_reg;
        node_next   = node_reg;
        dim_next    = dim_reg;
        vsize_next  = vsize_reg;
        ncount_next = ncount_reg;
        del_next    = del_reg;
        expsum_next = expsum_reg;
        remain_next = remain_reg;
        vhash_next  = vhash_reg;
        nhash_next  = nhash_reg;
        halted_next = halted_reg;
        n_res       = 2'd0;
        res0        = pack(KIND_PAYLOAD, ST_OK, 8'd0, 1'b0, '0, '0, '0, '0, '0, '0);
        res1        = res0;
        nb_bytes    = '0;
        total_bytes = '0;
        hdr_ok      = 1'b0;
        node_fits   = 1'b0;
        comb_h      = '0;
        fin_h       = '0;
        rem_dec     = remain_reg - 36'd1;
        fnv_out     = fnv_step((phase_reg == PH_VECTOR) ? vhash_reg : nhash_reg, b);

        if (accept)
        begin
            if (s_tuser)
            begin
                // end of log: report and return to reset state
                n_res = 2'd1;
                res0  = pack(KIND_END,
                             (!halted_reg && (phase_reg != PH_HEADER || hbc_reg != 6'd0))
                                 ? ST_TRUNCATED : ST_OK,
                             8'd0, 1'b0, '0, '0, '0, '0, '0, 32'd0);
                phase_next  = PH_HEADER;
                hbc_next    = '0;
                match_next  = 1'b1;
                seq_next    = '0;
                node_next   = '0;
                dim_next    = '0;
                vsize_next  = '0;
                ncount_next = '0;
                del_next    = '0;
                expsum_next = '0;
                remain_next = '0;
                vhash_next  = FNV_BASIS;
                nhash_next  = FNV_BASIS;
                halted_next = 1'b0;
            end
            else if (halted_reg)
            begin
                // dropped while halted
            end
            else if (phase_reg == PH_HEADER)
            begin
                // header capture
                priority if (hbc_reg < 6'd8)
                begin
                    if (b != PREFIX[hbc_reg[2:0]])
                        match_next = 1'b0;
                    else if (hbc_reg == 6'd0)
                        match_next = 1'b1;
                end
                else if (hbc_reg < 6'd16)
                    seq_next[{hbc_reg[2:0], 3'b000} +: 8] = b;
                else if (hbc_reg < 6'd24)
                    node_next[{hbc_reg[2:0], 3'b000} +: 8] = b;
                else if (hbc_reg < 6'd28)
                    dim_next[{hbc_reg[1:0], 3'b000} +: 8] = b;
                else if (hbc_reg < 6'd32)
                    vsize_next[{hbc_reg[1:0], 3'b000} +: 8] = b;
                else if (hbc_reg < 6'd36)
                    ncount_next[{hbc_reg[1:0], 3'b000} +: 8] = b;
                else if (hbc_reg == 6'd36)
                    del_next = b;
                else
                    expsum_next[{hbc_reg[1:0] - 2'd1, 3'b000} +: 8] = b;

                hbc_next = hbc_reg + 6'd1;
                if (hbc_reg == 6'(HDR_LEN - 1))
                begin
                    // header checks
                    hbc_next    = '0;
                    nb_bytes    = 36'(ncount_next) * 36'(NODE_ID_BYTES);
                    total_bytes = {5'd0, vsize_next} + {1'b0, nb_bytes};
                    hdr_ok = match_next && (del_next <= 8'd1) && (dim_next <= MAX_DIM)
                             && ({dim_next[29:0], 2'b00} == vsize_next)
                             && (total_bytes <= {1'b0, max_payload_reg});
                    node_fits = ((node_next >> NODE_BITS) == 64'd0);
                    comb_h = (ncount_next != 32'd0) ? hash_combine(vhash_reg, nhash_reg)
                                                    : vhash_reg;
                    priority if (!hdr_ok || !node_fits)
                    begin
                        n_res = 2'd1;
                        res0  = pack(KIND_VERDICT, hdr_ok ? ST_NODE_WIDE : ST_BAD_HDR, 8'd0,
                                     1'b1, seq_next, node_next, dim_next, ncount_next,
                                     del_next, 32'd0);
                        halted_next = 1'b1;
                    end
                    else if (vsize_next != 32'd0)
                    begin
                        phase_next  = PH_VECTOR;
                        remain_next = {4'd0, vsize_next};
                    end
                    else if (nb_bytes != 36'd0)
                    begin
                        phase_next  = PH_NEIGHBOR;
                        remain_next = nb_bytes;
                    end
                    else
                    begin
                        // empty payload: verdict now
                        n_res = 2'd1;
                        res0  = pack(KIND_VERDICT,
                                     (comb_h == expsum_next) ? ST_OK : ST_CHECKSUM, 8'd0,
                                     1'b1, seq_next, node_next, dim_next, ncount_next,
                                     del_next, comb_h);
                        if (comb_h != expsum_next)
                            halted_next = 1'b1;
                        match_next = 1'b1;
                        vhash_next = FNV_BASIS;
                        nhash_next = FNV_BASIS;
                    end
                end
            end
            else
            begin
                // payload byte pass and hash
                n_res = 2'd1;
                res0  = pack(KIND_PAYLOAD, ST_OK, b, 1'b1, seq_reg, node_reg, dim_reg,
                             ncount_reg, del_reg, 32'd0);
                if (phase_reg == PH_VECTOR)
                    vhash_next = fnv_out;
                else
                    nhash_next = fnv_out;
                remain_next = rem_dec;
                nb_bytes    = 36'(ncount_reg) * 36'(NODE_ID_BYTES);
                if (rem_dec == '0)
                begin
                    if (phase_reg == PH_VECTOR && ncount_reg != 32'd0)
                    begin
                        phase_next  = PH_NEIGHBOR;
                        remain_next = nb_bytes;
                    end
                    else
                    begin
                        fin_h = (ncount_reg != 32'd0) ? hash_combine(vhash_next, nhash_next)
                                                      : vhash_next;
                        n_res = 2'd2;
                        res1  = pack(KIND_VERDICT,
                                     (fin_h == expsum_reg) ? ST_OK : ST_CHECKSUM, 8'd0,
                                     1'b1, seq_reg, node_reg, dim_reg, ncount_reg,
                                     del_reg, fin_h);
                        if (fin_h != expsum_reg)
                            halted_next = 1'b1;
                        phase_next  = PH_HEADER;
                        hbc_next    = '0;
                        match_next  = 1'b1;
                        remain_next = '0;
                        vhash_next  = FNV_BASIS;
                        nhash_next  = FNV_BASIS;
                    end
                end
            end
        end
    end

    // control and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            phase_reg  <= PH_HEADER;
            hbc_reg    <= '0;
            match_reg  <= 1'b1;
            seq_reg    <= '0;
            node_reg   <= '0;
            dim_reg    <= '0;
            vsize_reg  <= '0;
            ncount_reg <= '0;
            del_reg    <= '0;
            expsum_reg <= '0;
            remain_reg <= '0;
            vhash_reg  <= FNV_BASIS;
            nhash_reg  <= FNV_BASIS;
            halted_reg <= 1'b0;
            q_wr_reg   <= '0;
            q_rd_reg   <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                max_payload_reg <= cfg_wdata;
            phase_reg  <= phase_next;
            hbc_reg    <= hbc_next;
            match_reg  <= match_next;
            seq_reg    <= seq_next;
            node_reg   <= node_next;
            dim_reg    <= dim_next;
            vsize_reg  <= vsize_next;
            ncount_reg <= ncount_next;
            del_reg    <= del_next;
            expsum_reg <= expsum_next;
            remain_reg <= remain_next;
            vhash_reg  <= vhash_next;
            nhash_reg  <= nhash_next;
            halted_reg <= halted_next;
            q_wr_reg   <= q_wr_reg + n_res;
            q_rd_reg   <= q_rd_reg + {1'b0, pop};
            q_cnt_reg  <= q_cnt_reg + {1'b0, n_res} - {2'b00, pop};
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
            q_mem[q_wr_reg] <= res0;
        if (n_res == 2'd2)
            q_mem[q_wr_reg + 2'd1] <= res1;
    end

    // checks
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_reg <= 3'd4)
        else $error("result queue overflow");
    a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (phase_reg == PH_HEADER && hbc_reg == 6'd0))
        else $error("halted inside a record");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> (!halted_reg && hbc_reg == 6'd0 && phase_reg == PH_HEADER))
        else $error("end of log did not clear state");
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("illegal result kind");

endmodule

`default_nettype wire

// ----- tb/log_record_replay_validator_tb.sv -----
// testbench for the log record validator: record stimulus, predictor and result scoreboard
`timescale 1ns / 1ps
`default_nettype none

import lrrv_pkg::*;

// queue of expected results with the checker
class verdict_board;
    result_t pending[$];
    int      errors;

    function new();
        errors = 0;
    endfunction

    // note one predicted result
    function void note(result_t r);
        pending = {pending, r};
    endfunction

    // compare an accepted result with the oldest prediction
    function void check(kind_t k, logic [TDATA_W-1:0] d);
        result_t w;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result kind %0d data %h", $time, k, d);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (w.kind !== k)
        begin
            $display("%0t: kind expected %0d actual %0d", $time, w.kind, k);
            errors++;
        end
        if (w.data !== d)
        begin
            $display("%0t: data expected %h actual %h", $time, w.data, d);
            errors++;
        end
    endfunction
endclass

module log_record_replay_validator_tb;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    verdict_board board;
    bit           calm;
    int           sent;

    // predictor state
    logic [CFG_W-1:0] p_limit;
    phase_t           p_phase;
    int               p_hcount;
    bit               p_match;
    logic [63:0]      p_seq;
    logic [63:0]      p_node;
    logic [31:0]      p_dim;
    logic [31:0]      p_vsize;
    logic [31:0]      p_ncount;
    logic [7:0]       p_del;
    logic [31:0]      p_sum;
    logic [35:0]      p_left;
    logic [31:0]      p_vhash;
    logic [31:0]      p_nhash;
    bit               p_halt;

    log_record_replay_validator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    // fnv-1a byte step
    function automatic logic [31:0] fnv(logic [31:0] h, logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * 32'd16777619;
    endfunction

    function automatic void new_record();
        p_phase  = PH_HEADER;
        p_hcount = 0;
        p_match  = 1;
        p_left   = '0;
        p_vhash  = FNV_BASIS;
        p_nhash  = FNV_BASIS;
    endfunction

    function automatic void clear_all();
        p_seq = '0; p_node = '0; p_dim = '0; p_vsize = '0; p_ncount = '0;
        p_del = '0; p_sum = '0; p_halt = 0;
        new_record();
    endfunction

    // build and note one result
    function automatic void post(kind_t k, status_t st, logic [7:0] pb, logic [31:0] cs,
                                 bit hdr);
        result_t r;
        r.kind = k;
        r.data = '0;
        r.data[2:0]   = st;
        r.data[10:3]  = pb;
        r.data[233:202] = cs;
        if (hdr)
        begin
            r.data[74:11]   = p_seq;
            r.data[138:75]  = p_node;
            r.data[168:139] = p_dim[29:0];
            r.data[200:169] = p_ncount;
            r.data[201]     = p_del[0];
        end
        board.note(r);
    endfunction

    function automatic void close_payload();
        logic [31:0] h;
        h = p_vhash;
        if (p_ncount != 0)
            h = h ^ (p_nhash + 32'h9e3779b9 + (h << 6) + (h >> 2));
        post(KIND_VERDICT, (h == p_sum) ? ST_OK : ST_CHECKSUM, 8'd0, h, 1);
        if (h != p_sum)
            p_halt = 1;
        new_record();
    endfunction

    function automatic void header_complete();
        logic [35:0] nb;
        bit ok;
        nb = {4'd0, p_ncount} * NODE_ID_BYTES;
        ok = p_match && p_del <= 1 && p_dim <= 32'h3FFFFFFF;
        if (ok && {4'd0, p_dim} * 4 != {4'd0, p_vsize})
            ok = 0;
        if (ok && {1'b0, p_vsize} + {1'b0, nb} > {1'b0, p_limit})
            ok = 0;
        if (!ok)
        begin
            post(KIND_VERDICT, ST_BAD_HDR, 8'd0, 32'd0, 1);
            p_halt = 1;
        end
        else if ((p_node >> NODE_BITS) != 0)
        begin
            post(KIND_VERDICT, ST_NODE_WIDE, 8'd0, 32'd0, 1);
            p_halt = 1;
        end
        else if (p_vsize != 0)
        begin
            p_phase = PH_VECTOR;
            p_left  = {4'd0, p_vsize};
        end
        else if (nb != 0)
        begin
            p_phase = PH_NEIGHBOR;
            p_left  = nb;
        end
        else
            close_payload();
    endfunction

    // predict the results of one accepted request
    function automatic void predict(bit mode, logic [7:0] b);
        int i;
        if (mode)
        begin
            post(KIND_END, (!p_halt && (p_phase != PH_HEADER || p_hcount != 0))
                 ? ST_TRUNCATED : ST_OK, 8'd0, 32'd0, 0);
            clear_all();
            return;
        end
        if (p_halt)
            return;
        if (p_phase == PH_HEADER)
        begin
            i = p_hcount;
            if (i < 8)
            begin
                if (b != PREFIX[i])
                    p_match = 0;
            end
            else if (i < 16) p_seq[(i-8)*8 +: 8] = b;
            else if (i < 24) p_node[(i-16)*8 +: 8] = b;
            else if (i < 28) p_dim[(i-24)*8 +: 8] = b;
            else if (i < 32) p_vsize[(i-28)*8 +: 8] = b;
            else if (i < 36) p_ncount[(i-32)*8 +: 8] = b;
            else if (i == 36) p_del = b;
            else p_sum[(i-37)*8 +: 8] = b;
            p_hcount = i + 1;
            if (p_hcount >= HDR_LEN)
            begin
                p_hcount = 0;
                header_complete();
            end
            return;
        end
        post(KIND_PAYLOAD, ST_OK, b, 32'd0, 1);
        if (p_phase == PH_VECTOR)
            p_vhash = fnv(p_vhash, b);
        else
            p_nhash = fnv(p_nhash, b);
        p_left = p_left - 1;
        if (p_left != 0)
            return;
        if (p_phase == PH_VECTOR && p_ncount != 0)
        begin
            p_phase = PH_NEIGHBOR;
            p_left  = {4'd0, p_ncount} * NODE_ID_BYTES;
            return;
        end
        close_payload();
    endfunction

    // send one request, with an occasional burst of idle cycles first
    task automatic send(bit mode, logic [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict(mode, b);
        sent++;
    endtask

    task automatic send_bytes(logic [7:0] q[$]);
        foreach (q[k])
            send(1'b0, q[k]);
    endtask

    // assemble a record; breakage selects a fault to inject
    task automatic send_record(int dim, int nbr, int breakage, logic [63:0] node,
                               bit use_payload_bytes);
        logic [7:0]  hdr[$];
        logic [7:0]  vec[$];
        logic [7:0]  nb[$];
        logic [31:0] vh;
        logic [31:0] nh;
        logic [31:0] h;
        logic [63:0] seq;
        logic [31:0] vs;
        logic [7:0]  del;
        int          k;
        vh = FNV_BASIS;
        nh = FNV_BASIS;
        seq = {$urandom, $urandom};
        for (k = 0; k < dim * 4; k++)
        begin
            vec = {vec, 8'($urandom_range(0, 255))};
            vh = fnv(vh, vec[k]);
        end
        for (k = 0; k < nbr * NODE_ID_BYTES; k++)
        begin
            nb = {nb, 8'($urandom_range(0, 255))};
            nh = fnv(nh, nb[k]);
        end
        h = vh;
        if (nbr != 0)
            h = h ^ (nh + 32'h9e3779b9 + (h << 6) + (h >> 2));
        vs  = dim * 4;
        del = 8'($urandom_range(0, 1));
        case (breakage)
            1: h = h ^ (32'd1 << $urandom_range(0, 31));
            2: vs = vs + 1;
            3: del = 8'($urandom_range(2, 255));
            default: ;
        endcase
        for (k = 0; k < 8; k++)
            hdr = {hdr, PREFIX[k]};
        if (breakage == 4)
            hdr[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
        for (k = 0; k < 8; k++) hdr = {hdr, seq[k*8 +: 8]};
        for (k = 0; k < 8; k++) hdr = {hdr, node[k*8 +: 8]};
        for (k = 0; k < 4; k++) hdr = {hdr, 8'(dim >> (k*8))};
        for (k = 0; k < 4; k++) hdr = {hdr, vs[k*8 +: 8]};
        for (k = 0; k < 4; k++) hdr = {hdr, 8'(nbr >> (k*8))};
        hdr = {hdr, del};
        for (k = 0; k < 4; k++) hdr = {hdr, h[k*8 +: 8]};
        send_bytes(hdr);
        if (use_payload_bytes)
        begin
            send_bytes(vec);
            send_bytes(nb);
        end
    endtask

    task automatic send_header_raw(logic [31:0] dim, logic [31:0] vs, logic [31:0] nbr);
        logic [7:0] hdr[$];
        int k;
        for (k = 0; k < 8; k++) hdr = {hdr, PREFIX[k]};
        for (k = 0; k < 16; k++) hdr = {hdr, 8'h00};
        for (k = 0; k < 4; k++) hdr = {hdr, dim[k*8 +: 8]};
        for (k = 0; k < 4; k++) hdr = {hdr, vs[k*8 +: 8]};
        for (k = 0; k < 4; k++) hdr = {hdr, nbr[k*8 +: 8]};
        for (k = 0; k < 5; k++) hdr = {hdr, 8'h00};
        send_bytes(hdr);
    endtask

    // wait until every prediction has arrived, then let the block settle
    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_limit(logic [CFG_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        p_limit = v;
    endtask

    // result side: random stalls, checking on every accepted result
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check(kind_t'(m_tuser), m_tdata);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6))
                begin
                    @(posedge clk);
                end
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int k;
        int d;
        int n;
        board     = new();
        calm      = 0;
        sent      = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        p_limit   = MAX_PAYLOAD_RESET;
        clear_all();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty record, good record, checksum fault, each header fault, truncation
        send_record(0, 0, 0, 64'd0, 1);
        send_record(1, 1, 0, 64'hFFFF_FFFF, 1);
        send(1'b1, 8'hFF);
        send_record(1, 0, 1, 64'd5, 1);
        send(1'b0, 8'hAA);
        send(1'b1, 8'h00);
        send_record(0, 0, 4, 64'd0, 1);
        send(1'b1, 8'h00);
        send_record(0, 0, 2, 64'd0, 1);
        send(1'b1, 8'h00);
        send_record(0, 0, 3, 64'd0, 1);
        send(1'b1, 8'h00);
        send_record(0, 0, 0, 64'h1_0000_0000, 1);
        send(1'b1, 8'h00);
        send_header_raw(32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'd0);
        send(1'b1, 8'h00);
        send_header_raw(32'h3FFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send(1'b1, 8'h00);
        send_record(2, 1, 0, 64'd7, 0);
        send(1'b0, 8'h80);
        send(1'b1, 8'h00);

        // limit of zero: only empty records pass; an all-ones limit follows
        set_limit('0);
        send_record(0, 0, 0, 64'd1, 1);
        send_record(1, 0, 0, 64'd1, 1);
        send(1'b1, 8'h00);
        set_limit('1);
        send_header_raw(32'h3FFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send(1'b1, 8'h00);
        set_limit(36'd12);

        // random records: mostly well formed, some faults and noise
        while (sent < 660)
        begin
            if (sent > 540)
                calm = 1;
            d = $urandom_range(0, 3);
            n = $urandom_range(0, 2);
            case ($urandom_range(0, 11))
                0: send_record(d, n, $urandom_range(1, 4), {$urandom, $urandom}, 1);
                1: send_record(d, n, 0, {$urandom_range(0, 1), $urandom}, 1);
                2: send(1'b1, 8'($urandom_range(0, 255)));
                3:
                begin
                    for (k = 0; k < $urandom_range(1, 50); k++)
                        send(1'b0, 8'($urandom_range(0, 255)));
                    send(1'b1, 8'h00);
                end
                default: send_record(d, n, 0, {32'd0, $urandom}, 1);
            endcase
            if (p_halt)
                send(1'b1, 8'h00);
        end
        set_limit(MAX_PAYLOAD_RESET);
        send_record(2, 2, 0, 64'd3, 1);
        send(1'b1, 8'h00);
        drain();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
